FILE: rtl/tcptmr_pkg.sv
// ----------------------------------------------------------------------------
// tcptmr_pkg
// Shared types and constants of the retransmit and time-wait timer table:
// command and event codes, register indexes, reset values and the
// controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package tcptmr_pkg;

	// default geometry of the table
	localparam int SOCKETS_DEF = 8;
	localparam int SLOTS_DEF   = 4;

	// field widths
	localparam int TW_W    = 16;
	localparam int RT_W    = 12;
	localparam int CD_W    = 14;
	localparam int TRIES_W = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register reset values
	localparam logic [TW_W-1:0] TIMEWAIT_RESET = 16'd20;
	localparam logic [RT_W-1:0] RETRANS_RESET  = 12'd2;

	// try count thresholds
	localparam logic [TRIES_W-1:0] TRIES_LOSS    = 3'd3;
	localparam logic [TRIES_W-1:0] TRIES_RESTART = 3'd1;
	localparam logic [TRIES_W-1:0] TRIES_DOUBLE  = 3'd2;

	// register indexes (paddr[2])
	localparam logic REG_TIMEWAIT = 1'b0;
	localparam logic REG_RETRANS  = 1'b1;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_ARM_TW  = 3'd1,
		CMD_ARM_RT  = 3'd2,
		CMD_DIS_RT  = 3'd3,
		CMD_ADD     = 3'd4,
		CMD_REMOVE  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		EV_DONE    = 3'd0,
		EV_IGNORED = 3'd1,
		EV_RESEND  = 3'd2,
		EV_LOSS    = 3'd3,
		EV_CLOSE   = 3'd4,
		EV_TICK    = 3'd5
	} event_t;

	// controller to datapath step commands
	typedef struct packed {
		logic exec;
		logic tw_step;
		logic rd_step;
		logic up_step;
		logic fin_step;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic rt_armed;
		logic pkt_valid;
	} stat_t;

endpackage

FILE: rtl/tcptmr_cfg.sv
// ----------------------------------------------------------------------------
// tcptmr_cfg
// APB register block holding the time-wait limit and the base
// retransmission interval.
// ----------------------------------------------------------------------------
module tcptmr_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tcptmr_pkg::PADDR_W-1:0]         paddr,
	input  logic [tcptmr_pkg::PDATA_W-1:0]         pwdata,
	output logic [tcptmr_pkg::PDATA_W-1:0]         prdata,
	output logic                                   pready,
	output logic [tcptmr_pkg::TW_W-1:0]            timewait_ticks,
	output logic [tcptmr_pkg::RT_W-1:0]            retrans_ticks
);

	logic [tcptmr_pkg::TW_W-1:0] timewait_q;
	logic [tcptmr_pkg::RT_W-1:0] retrans_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timewait_q <= tcptmr_pkg::TIMEWAIT_RESET;
			retrans_q  <= tcptmr_pkg::RETRANS_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				tcptmr_pkg::REG_TIMEWAIT: timewait_q <= pwdata[tcptmr_pkg::TW_W-1:0];
				tcptmr_pkg::REG_RETRANS:  retrans_q  <= pwdata[tcptmr_pkg::RT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tcptmr_pkg::REG_TIMEWAIT: prdata = tcptmr_pkg::PDATA_W'(timewait_q);
			tcptmr_pkg::REG_RETRANS:  prdata = tcptmr_pkg::PDATA_W'(retrans_q);
			default:                  prdata = '0;
		endcase
	end

	assign timewait_ticks = timewait_q;
	assign retrans_ticks  = retrans_q;

endmodule

FILE: rtl/tcptmr_ctrl.sv
// ----------------------------------------------------------------------------
// tcptmr_ctrl
// Sequencer of the table: takes commands; a tick walks every socket (time-wait
// step, then, if retransmit is armed, its slots as read and update steps).
// ----------------------------------------------------------------------------
module tcptmr_ctrl #(
	parameter int SOCKETS          = tcptmr_pkg::SOCKETS_DEF,
	parameter int SLOTS_PER_SOCKET = tcptmr_pkg::SLOTS_DEF,
	localparam int SOCK_W = (SOCKETS > 1) ? $clog2(SOCKETS) : 1,
	localparam int SLOT_W = (SLOTS_PER_SOCKET > 1) ? $clog2(SLOTS_PER_SOCKET) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          cmd,
	input  tcptmr_pkg::stat_t   stat,
	output tcptmr_pkg::ctl_t    ctl,
	output logic [SOCK_W-1:0]   walk_sock,
	output logic [SLOT_W-1:0]   walk_slot,
	output logic                busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_TW   = 5'b00010,
		ST_RD   = 5'b00100,
		ST_UP   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [SOCK_W-1:0]   sock_q, sock_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic                last_sock, last_slot;
	logic                accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign last_sock = (sock_q == SOCK_W'(SOCKETS - 1));
	assign last_slot = (slot_q == SLOT_W'(SLOTS_PER_SOCKET - 1));

	always_comb begin
		state_d = state_q;
		sock_d  = sock_q;
		slot_d  = slot_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == tcptmr_pkg::CMD_TICK)) begin
					sock_d  = '0;
					state_d = ST_TW;
				end
			end
			ST_TW: begin
				if (stat.rt_armed) begin
					slot_d  = '0;
					state_d = ST_RD;
				end else if (last_sock) begin
					state_d = ST_FIN;
				end else begin
					sock_d  = sock_q + SOCK_W'(1);
					state_d = ST_TW;
				end
			end
			ST_RD, ST_UP: begin
				if ((state_q == ST_RD) && stat.pkt_valid) begin
					state_d = ST_UP;
				end else if (!last_slot) begin
					slot_d  = slot_q + SLOT_W'(1);
					state_d = ST_RD;
				end else if (last_sock) begin
					state_d = ST_FIN;
				end else begin
					sock_d  = sock_q + SOCK_W'(1);
					state_d = ST_TW;
				end
			end
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sock_q  <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			sock_q  <= sock_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		ctl.exec     = accept && (cmd != tcptmr_pkg::CMD_TICK);
		ctl.tw_step  = (state_q == ST_TW);
		ctl.rd_step  = (state_q == ST_RD);
		ctl.up_step  = (state_q == ST_UP);
		ctl.fin_step = (state_q == ST_FIN);
	end

	assign walk_sock = sock_q;
	assign walk_slot = slot_q;
	assign busy      = (state_q != ST_IDLE);

endmodule

FILE: rtl/tcptmr_dp.sv
// ----------------------------------------------------------------------------
// tcptmr_dp
// Datapath of the table: socket flags and time-wait counters, packet valid
// bits, the packet countdown memory and the result register.
// ----------------------------------------------------------------------------
module tcptmr_dp #(
	parameter int SOCKETS          = tcptmr_pkg::SOCKETS_DEF,
	parameter int SLOTS_PER_SOCKET = tcptmr_pkg::SLOTS_DEF,
	localparam int SOCK_W = (SOCKETS > 1) ? $clog2(SOCKETS) : 1,
	localparam int SLOT_W = (SLOTS_PER_SOCKET > 1) ? $clog2(SLOTS_PER_SOCKET) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tcptmr_pkg::ctl_t                    ctl,
	output tcptmr_pkg::stat_t                   stat,
	input  logic [SOCK_W-1:0]                   walk_sock,
	input  logic [SLOT_W-1:0]                   walk_slot,
	input  logic [2:0]                          cmd,
	input  logic [2:0]                          sock_id,
	input  logic [1:0]                          slot_id,
	input  logic [1:0]                          start_tries,
	input  logic [tcptmr_pkg::CD_W-1:0]         start_countdown,
	input  logic [tcptmr_pkg::TW_W-1:0]         timewait_ticks,
	input  logic [tcptmr_pkg::RT_W-1:0]         retrans_ticks,
	output logic                                event_valid,
	output logic [2:0]                          event_res,
	output logic [2:0]                          event_sock,
	output logic [1:0]                          event_slot,
	output logic [2:0]                          event_tries,
	output logic                                last
);

	localparam int NPKT  = SOCKETS * SLOTS_PER_SOCKET;
	localparam int PKT_W = (NPKT > 1) ? $clog2(NPKT) : 1;
	localparam int ENT_W = tcptmr_pkg::TRIES_W + tcptmr_pkg::CD_W;
	localparam int CD_W  = tcptmr_pkg::CD_W;
	localparam int TR_W  = tcptmr_pkg::TRIES_W;

	logic [SOCKETS-1:0]              tw_armed_q;
	logic [tcptmr_pkg::TW_W-1:0]     tw_count_q [SOCKETS];
	logic [SOCKETS-1:0]              rt_armed_q;
	logic [NPKT-1:0]                 pkt_valid_q;
	logic [ENT_W-1:0]                pkt_mem [NPKT];
	logic [ENT_W-1:0]                rd_q;

	logic                            ev_valid_q;
	logic [2:0]                      ev_res_q;
	logic [2:0]                      ev_sock_q;
	logic [1:0]                      ev_slot_q;
	logic [2:0]                      ev_tries_q;
	logic                            ev_last_q;

	// command decode
	logic                            sock_ok, slot_ok;
	logic [SOCK_W-1:0]               c_sock;
	logic [SLOT_W-1:0]               c_slot;
	logic [PKT_W-1:0]                c_p, w_p;
	tcptmr_pkg::event_t              ex_res;
	logic                            ex_tw_arm, ex_rt_set, ex_rt_clr, ex_add, ex_rem;

	// tick step values
	logic [tcptmr_pkg::TW_W-1:0]     tw_cur, tw_inc;
	logic                            tw_close;
	logic [CD_W-1:0]                 up_cd;
	logic [TR_W-1:0]                 up_tries, up_tries_new;
	logic [ENT_W-1:0]                up_wdata;
	logic                            up_emit;
	tcptmr_pkg::event_t              up_res;

	assign sock_ok = (5'(sock_id) < 5'(SOCKETS));
	assign slot_ok = (3'(slot_id) < 3'(SLOTS_PER_SOCKET));
	assign c_sock  = SOCK_W'(sock_id);
	assign c_slot  = SLOT_W'(slot_id);
	assign c_p     = PKT_W'(int'(c_sock) * SLOTS_PER_SOCKET + int'(c_slot));
	assign w_p     = PKT_W'(int'(walk_sock) * SLOTS_PER_SOCKET + int'(walk_slot));

	assign stat.rt_armed  = rt_armed_q[walk_sock];
	assign stat.pkt_valid = pkt_valid_q[w_p];

	always_comb begin
		ex_res    = tcptmr_pkg::EV_IGNORED;
		ex_tw_arm = 1'b0;
		ex_rt_set = 1'b0;
		ex_rt_clr = 1'b0;
		ex_add    = 1'b0;
		ex_rem    = 1'b0;
		if (sock_ok) begin
			case (cmd)
				tcptmr_pkg::CMD_ARM_TW: begin
					ex_tw_arm = 1'b1;
					ex_res    = tcptmr_pkg::EV_DONE;
				end
				tcptmr_pkg::CMD_ARM_RT: begin
					if (!rt_armed_q[c_sock]) begin
						ex_rt_set = 1'b1;
						ex_res    = tcptmr_pkg::EV_DONE;
					end
				end
				tcptmr_pkg::CMD_DIS_RT: begin
					if (rt_armed_q[c_sock]) begin
						ex_rt_clr = 1'b1;
						ex_res    = tcptmr_pkg::EV_DONE;
					end
				end
				tcptmr_pkg::CMD_ADD: begin
					if (slot_ok) begin
						ex_add = 1'b1;
						ex_res = tcptmr_pkg::EV_DONE;
					end
				end
				tcptmr_pkg::CMD_REMOVE: begin
					if (slot_ok && pkt_valid_q[c_p]) begin
						ex_rem = 1'b1;
						ex_res = tcptmr_pkg::EV_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	// time-wait step: saturating count, close once the limit is reached
	assign tw_cur   = tw_count_q[walk_sock];
	assign tw_inc   = (tw_cur != '1) ? tw_cur + 16'd1 : tw_cur;
	assign tw_close = tw_armed_q[walk_sock] && (tw_inc >= timewait_ticks);

	// packet step on the entry read in the previous cycle
	always_comb begin
		up_tries     = rd_q[ENT_W-1:CD_W];
		up_cd        = rd_q[CD_W-1:0] - CD_W'(1);
		up_tries_new = up_tries;
		up_wdata     = {up_tries, up_cd};
		up_emit      = 1'b0;
		up_res       = tcptmr_pkg::EV_RESEND;
		if (up_cd == '0) begin
			up_emit = 1'b1;
			if (up_tries == tcptmr_pkg::TRIES_LOSS) begin
				up_tries_new = tcptmr_pkg::TRIES_RESTART;
				up_res       = tcptmr_pkg::EV_LOSS;
				up_wdata     = {up_tries_new, CD_W'(retrans_ticks)};
			end else begin
				up_tries_new = up_tries + TR_W'(1);
				if (up_tries_new == tcptmr_pkg::TRIES_DOUBLE)
					up_wdata = {up_tries_new, 1'b0, retrans_ticks, 1'b0};
				else
					up_wdata = {up_tries_new, retrans_ticks, 2'b00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_armed_q <= '0;
			rt_armed_q <= '0;
			for (int i = 0; i < SOCKETS; i++)
				tw_count_q[i] <= '0;
		end else begin
			if (ctl.exec && ex_tw_arm) begin
				tw_armed_q[c_sock] <= 1'b1;
				tw_count_q[c_sock] <= '0;
			end else if (ctl.tw_step && tw_armed_q[walk_sock]) begin
				tw_count_q[walk_sock] <= tw_inc;
				if (tw_close)
					tw_armed_q[walk_sock] <= 1'b0;
			end
			if (ctl.exec && ex_rt_set)
				rt_armed_q[c_sock] <= 1'b1;
			else if (ctl.exec && ex_rt_clr)
				rt_armed_q[c_sock] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= '0;
		end else if (ctl.exec && ex_add) begin
			pkt_valid_q[c_p] <= 1'b1;
		end else if (ctl.exec && ex_rem) begin
			pkt_valid_q[c_p] <= 1'b0;
		end
	end

	// packet memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.exec && ex_add)
			pkt_mem[c_p] <= {1'b0, start_tries, start_countdown};
		else if (ctl.up_step)
			pkt_mem[w_p] <= up_wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_step)
			rd_q <= pkt_mem[w_p];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ev_valid_q <= 1'b0;
		else
			ev_valid_q <= ctl.exec || (ctl.tw_step && tw_close) ||
				(ctl.up_step && up_emit) || ctl.fin_step;
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			ev_res_q   <= ex_res;
			ev_sock_q  <= sock_id;
			ev_slot_q  <= ((cmd == tcptmr_pkg::CMD_ADD) || (cmd == tcptmr_pkg::CMD_REMOVE)) ?
				slot_id : 2'd0;
			ev_tries_q <= '0;
			ev_last_q  <= 1'b1;
		end else if (ctl.tw_step) begin
			ev_res_q   <= tcptmr_pkg::EV_CLOSE;
			ev_sock_q  <= 3'(walk_sock);
			ev_slot_q  <= '0;
			ev_tries_q <= '0;
			ev_last_q  <= 1'b0;
		end else if (ctl.up_step) begin
			ev_res_q   <= up_res;
			ev_sock_q  <= 3'(walk_sock);
			ev_slot_q  <= 2'(walk_slot);
			ev_tries_q <= up_tries_new;
			ev_last_q  <= 1'b0;
		end else begin
			ev_res_q   <= tcptmr_pkg::EV_TICK;
			ev_sock_q  <= '0;
			ev_slot_q  <= '0;
			ev_tries_q <= '0;
			ev_last_q  <= 1'b1;
		end
	end

	assign event_valid = ev_valid_q;
	assign event_res   = ev_res_q;
	assign event_sock  = ev_sock_q;
	assign event_slot  = ev_slot_q;
	assign event_tries = ev_tries_q;
	assign last        = ev_last_q;

endmodule

FILE: rtl/tcp_retrans_timewait_timer_table.sv
// ----------------------------------------------------------------------------
// tcp_retrans_timewait_timer_table
// Per-socket time-wait and retransmit timers with a table of per-packet
// countdowns and try counts.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken at a rising edge with start high and busy low.
//   Every result comes out registered for one cycle with event_valid high;
//   the receiver cannot stall, so results are never held back. last marks
//   the final result of an item.
//   Socket and packet commands finish in the cycle they are taken; their
//   single result shows the next cycle and busy stays low, so one command
//   can be taken every cycle.
//   A tick walks the sockets one after another: a time-wait counter step,
//   then, if the socket is armed for retransmission, a read step for every
//   slot, followed by an update step for a filled slot (countdown memory
//   read, then update); busy is high while it runs. Close, resend and loss
//   results follow in walk order and the tick done result ends it.
//   The user must write the registers over APB only while the block is
//   idle; the block itself does not enforce it. Reset clears all flags,
//   time-wait counters and valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module tcp_retrans_timewait_timer_table #(
	parameter int SOCKETS          = tcptmr_pkg::SOCKETS_DEF,
	parameter int SLOTS_PER_SOCKET = tcptmr_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          cmd,
	input  logic [2:0]                          sock_id,
	input  logic [1:0]                          slot_id,
	input  logic [1:0]                          start_tries,
	input  logic [tcptmr_pkg::CD_W-1:0]         start_countdown,
	output logic                                event_valid,
	output logic [2:0]                          event_res,
	output logic [2:0]                          event_sock,
	output logic [1:0]                          event_slot,
	output logic [2:0]                          event_tries,
	output logic                                last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcptmr_pkg::PADDR_W-1:0]      paddr,
	input  logic [tcptmr_pkg::PDATA_W-1:0]      pwdata,
	output logic [tcptmr_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int SOCK_W = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
	localparam int SLOT_W = (SLOTS_PER_SOCKET > 1) ? $clog2(SLOTS_PER_SOCKET) : 1;

	tcptmr_pkg::ctl_t             ctl;
	tcptmr_pkg::stat_t            stat;
	logic [SOCK_W-1:0]            walk_sock;
	logic [SLOT_W-1:0]            walk_slot;
	logic [tcptmr_pkg::TW_W-1:0]  timewait_ticks;
	logic [tcptmr_pkg::RT_W-1:0]  retrans_ticks;

	tcptmr_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.timewait_ticks (timewait_ticks),
		.retrans_ticks  (retrans_ticks)
	);

	tcptmr_ctrl #(
		.SOCKETS          (SOCKETS),
		.SLOTS_PER_SOCKET (SLOTS_PER_SOCKET)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.stat      (stat),
		.ctl       (ctl),
		.walk_sock (walk_sock),
		.walk_slot (walk_slot),
		.busy      (busy)
	);

	tcptmr_dp #(
		.SOCKETS          (SOCKETS),
		.SLOTS_PER_SOCKET (SLOTS_PER_SOCKET)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.walk_sock       (walk_sock),
		.walk_slot       (walk_slot),
		.cmd             (cmd),
		.sock_id         (sock_id),
		.slot_id         (slot_id),
		.start_tries     (start_tries),
		.start_countdown (start_countdown),
		.timewait_ticks  (timewait_ticks),
		.retrans_ticks   (retrans_ticks),
		.event_valid     (event_valid),
		.event_res       (event_res),
		.event_sock      (event_sock),
		.event_slot      (event_slot),
		.event_tries     (event_tries),
		.last            (last)
	);

`ifndef SYNTHESIS
	// a single-result command answers in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd != tcptmr_pkg::CMD_TICK) |=> event_valid && last)
		else $error("command result missing");

	// a tick occupies the block
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == tcptmr_pkg::CMD_TICK) |=> busy)
		else $error("tick did not start the walk");

	// intermediate results only come out of a running tick
	assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !last |-> busy)
		else $error("non-final result outside a tick");

	// the final result of an item leaves the block free
	assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && last |-> !busy)
		else $error("final result while still busy");
`endif

endmodule

FILE: sim/tcp_retrans_timewait_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_retrans_timewait_timer_table_tb
// Drives command items into the timer table and checks every event against
// a cycle-free model of the sockets and packet slots. A short table of
// directed commands comes first, then phases of random commands, each after
// the first under its own register setting written and read back over APB.
// ----------------------------------------------------------------------------
module tcp_retrans_timewait_timer_table_tb;

	localparam int SOCKETS = tcptmr_pkg::SOCKETS_DEF;
	localparam int SLOTS   = tcptmr_pkg::SLOTS_DEF;
	localparam int PKTS    = SOCKETS * SLOTS;

	localparam int PADDR_W = tcptmr_pkg::PADDR_W;
	localparam int PDATA_W = tcptmr_pkg::PDATA_W;
	localparam int CD_W    = tcptmr_pkg::CD_W;
	localparam int TRIES_W = tcptmr_pkg::TRIES_W;
	localparam int TW_W    = tcptmr_pkg::TW_W;
	localparam int RT_W    = tcptmr_pkg::RT_W;

	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	localparam logic [PADDR_W-1:0] ADDR_TIMEWAIT = {tcptmr_pkg::REG_TIMEWAIT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_RETRANS  = {tcptmr_pkg::REG_RETRANS, 2'b00};

	localparam int TICK_CYCLES     = 2 + SOCKETS + 2 * PKTS;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 50;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [2:0]      sock;
		logic [1:0]      slot;
		logic [1:0]      tries;
		logic [CD_W-1:0] countdown;
	} timer_cmd_t;

	typedef struct packed {
		tcptmr_pkg::event_t res;
		logic [2:0]         sock;
		logic [1:0]         slot;
		logic [TRIES_W-1:0] tries;
		logic               last;
	} timer_event_t;

	typedef struct packed {
		timer_cmd_t   item;
		logic         typed;
		timer_event_t ev;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         cmd;
	logic [2:0]         sock_id;
	logic [1:0]         slot_id;
	logic [1:0]         start_tries;
	logic [CD_W-1:0]    start_countdown;
	logic               event_valid;
	logic [2:0]         event_res;
	logic [2:0]         event_sock;
	logic [1:0]         event_slot;
	logic [2:0]         event_tries;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// model of the table
	logic [TW_W-1:0]    tw_limit;
	logic [RT_W-1:0]    rt_base;
	logic               tw_on [SOCKETS];
	logic [TW_W-1:0]    tw_cnt [SOCKETS];
	logic               rt_on [SOCKETS];
	logic               slot_full [PKTS];
	logic [CD_W-1:0]    slot_cd [PKTS];
	logic [TRIES_W-1:0] slot_tries [PKTS];

	timer_event_t step_events[$];
	timer_event_t expected_events[$];
	plan_row_t    plan[$];
	int           fail_count = 0;
	int           idle_pct = 35;

	tcp_retrans_timewait_timer_table #(
		.SOCKETS          (SOCKETS),
		.SLOTS_PER_SOCKET (SLOTS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.sock_id         (sock_id),
		.slot_id         (slot_id),
		.start_tries     (start_tries),
		.start_countdown (start_countdown),
		.event_valid     (event_valid),
		.event_res       (event_res),
		.event_sock      (event_sock),
		.event_slot      (event_slot),
		.event_tries     (event_tries),
		.last            (last),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_event(input tcptmr_pkg::event_t r, input logic [2:0] s,
			input logic [1:0] k, input logic [TRIES_W-1:0] t, input logic l);
		timer_event_t ev;
		ev.res   = r;
		ev.sock  = s;
		ev.slot  = k;
		ev.tries = t;
		ev.last  = l;
		step_events.push_back(ev);
	endfunction

	function automatic void predict_command(input timer_cmd_t it);
		int                 p;
		tcptmr_pkg::event_t res;
		logic [1:0]         rslot;
		logic               in_range;
		step_events.delete();
		if (it.cmd == tcptmr_pkg::CMD_TICK) begin
			for (int s = 0; s < SOCKETS; s++) begin
				if (tw_on[s]) begin
					if (tw_cnt[s] != '1)
						tw_cnt[s] = tw_cnt[s] + 1'b1;
					if (tw_cnt[s] >= tw_limit) begin
						tw_on[s] = 1'b0;
						note_event(tcptmr_pkg::EV_CLOSE, 3'(s), 2'd0, 3'd0, 1'b0);
					end
				end
				if (!rt_on[s])
					continue;
				for (int k = 0; k < SLOTS; k++) begin
					p = s * SLOTS + k;
					if (!slot_full[p])
						continue;
					// zero wraps to the top of the 14-bit range
					slot_cd[p] = slot_cd[p] - 1'b1;
					if (slot_cd[p] != '0)
						continue;
					if (slot_tries[p] == tcptmr_pkg::TRIES_LOSS) begin
						slot_tries[p] = tcptmr_pkg::TRIES_RESTART;
						slot_cd[p]    = {2'b00, rt_base};
						note_event(tcptmr_pkg::EV_LOSS, 3'(s), 2'(k), slot_tries[p], 1'b0);
					end else begin
						slot_tries[p] = slot_tries[p] + 1'b1;
						slot_cd[p]    = (slot_tries[p] == tcptmr_pkg::TRIES_DOUBLE) ?
							{1'b0, rt_base, 1'b0} : {rt_base, 2'b00};
						note_event(tcptmr_pkg::EV_RESEND, 3'(s), 2'(k), slot_tries[p], 1'b0);
					end
				end
			end
			note_event(tcptmr_pkg::EV_TICK, 3'd0, 2'd0, 3'd0, 1'b1);
			return;
		end
		res   = tcptmr_pkg::EV_IGNORED;
		rslot = (it.cmd == tcptmr_pkg::CMD_ADD || it.cmd == tcptmr_pkg::CMD_REMOVE) ?
			it.slot : 2'd0;
		// socket and slot outside the table are ignored
		in_range = (int'(it.sock) < SOCKETS) &&
			((it.cmd != tcptmr_pkg::CMD_ADD && it.cmd != tcptmr_pkg::CMD_REMOVE) ||
			(int'(it.slot) < SLOTS));
		p     = it.sock * SLOTS + it.slot;
		if (in_range) begin
			case (it.cmd)
				tcptmr_pkg::CMD_ARM_TW: begin
					tw_on[it.sock]  = 1'b1;
					tw_cnt[it.sock] = '0;
					res             = tcptmr_pkg::EV_DONE;
				end
				tcptmr_pkg::CMD_ARM_RT: if (!rt_on[it.sock]) begin
					rt_on[it.sock] = 1'b1;
					res            = tcptmr_pkg::EV_DONE;
				end
				tcptmr_pkg::CMD_DIS_RT: if (rt_on[it.sock]) begin
					rt_on[it.sock] = 1'b0;
					res            = tcptmr_pkg::EV_DONE;
				end
				tcptmr_pkg::CMD_ADD: begin
					slot_full[p]  = 1'b1;
					slot_cd[p]    = it.countdown;
					slot_tries[p] = {1'b0, it.tries};
					res           = tcptmr_pkg::EV_DONE;
				end
				tcptmr_pkg::CMD_REMOVE: if (slot_full[p]) begin
					slot_full[p] = 1'b0;
					res          = tcptmr_pkg::EV_DONE;
				end
				default: ;
			endcase
		end
		note_event(res, it.sock, rslot, 3'd0, 1'b1);
	endfunction

	function automatic plan_row_t mk(input logic [2:0] c, input logic [2:0] s,
			input logic [1:0] k, input logic [1:0] t, input logic [CD_W-1:0] cd,
			input logic typed, input tcptmr_pkg::event_t r, input logic [2:0] es,
			input logic [1:0] ek);
		plan_row_t row;
		row.item     = '{c, s, k, t, cd};
		row.typed    = typed;
		row.ev.res   = r;
		row.ev.sock  = es;
		row.ev.slot  = ek;
		row.ev.tries = 3'd0;
		row.ev.last  = 1'b1;
		return row;
	endfunction

	function automatic timer_cmd_t random_command();
		timer_cmd_t it;
		int         r;
		r = $urandom_range(99);
		if (r < 34)
			it.cmd = tcptmr_pkg::CMD_TICK;
		else if (r < 42)
			it.cmd = tcptmr_pkg::CMD_ARM_TW;
		else if (r < 52)
			it.cmd = tcptmr_pkg::CMD_ARM_RT;
		else if (r < 57)
			it.cmd = tcptmr_pkg::CMD_DIS_RT;
		else if (r < 82)
			it.cmd = tcptmr_pkg::CMD_ADD;
		else if (r < 95)
			it.cmd = tcptmr_pkg::CMD_REMOVE;
		else
			it.cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
		it.sock  = 3'($urandom);
		it.slot  = 2'($urandom);
		it.tries = 2'($urandom);
		// short countdowns keep resends and losses coming
		it.countdown = ($urandom_range(99) < 85) ? CD_W'($urandom_range(1, 10)) :
			CD_W'($urandom);
		return it;
	endfunction

	task automatic send_item(input plan_row_t row);
		int gap;
		gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		cmd             <= row.item.cmd;
		sock_id         <= row.item.sock;
		slot_id         <= row.item.slot;
		start_tries     <= row.item.tries;
		start_countdown <= row.item.countdown;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predict_command(row.item);
		if (row.typed)
			expected_events.push_back(row.ev);
		else
			foreach (step_events[i])
				expected_events.push_back(step_events[i]);
	endtask

	task automatic drain_events();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_events.size() != 0);
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr[2] == tcptmr_pkg::REG_TIMEWAIT)
			tw_limit = value[TW_W-1:0];
		else
			rt_base = value[RT_W-1:0];
	endtask

	task automatic reg_read_check(input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== want) begin
			fail_count++;
			$display("%0t: register read at %0d: expected %0d, got %0d",
				$time, addr, want, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		timer_event_t got;
		timer_event_t want;
		if (arst_n === 1'b1 && event_valid === 1'b1) begin
			got.res   = tcptmr_pkg::event_t'(event_res);
			got.sock  = event_sock;
			got.slot  = event_slot;
			got.tries = event_tries;
			got.last  = last;
			if (expected_events.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected event res=%0d sock=%0d slot=%0d tries=%0d last=%0d",
					$time, got.res, got.sock, got.slot, got.tries, got.last);
			end else begin
				want = expected_events.pop_front();
				if (got !== want) begin
					fail_count++;
					// fields: res sock slot tries last
					$display("%0t: mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
						$time, want.res, want.sock, want.slot, want.tries, want.last,
						got.res, got.sock, got.slot, got.tries, got.last);
				end
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		plan_row_t       row;
		logic [TW_W-1:0] new_tw;
		logic [RT_W-1:0] new_rt;

		arst_n          <= 1'b0;
		start           <= 1'b0;
		cmd             <= tcptmr_pkg::CMD_TICK;
		sock_id         <= '0;
		slot_id         <= '0;
		start_tries     <= '0;
		start_countdown <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;

		tw_limit = tcptmr_pkg::TIMEWAIT_RESET;
		rt_base  = tcptmr_pkg::RETRANS_RESET;
		for (int s = 0; s < SOCKETS; s++) begin
			tw_on[s]  = 1'b0;
			tw_cnt[s] = '0;
			rt_on[s]  = 1'b0;
		end
		for (int p = 0; p < PKTS; p++) begin
			slot_full[p]  = 1'b0;
			slot_cd[p]    = '0;
			slot_tries[p] = '0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		reg_read_check(ADDR_TIMEWAIT, {16'd0, tcptmr_pkg::TIMEWAIT_RESET});
		reg_read_check(ADDR_RETRANS, {20'd0, tcptmr_pkg::RETRANS_RESET});

		//                cmd                     sk sl tr count  typed result sk sl
		plan.push_back(mk(tcptmr_pkg::CMD_TICK,   0, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_TICK, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_DIS_RT, 0, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_IGNORED, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_REMOVE, 3, 2, 0, 0,     1'b1,
			tcptmr_pkg::EV_IGNORED, 3, 2));
		plan.push_back(mk(CMD_UNUSED_6,           5, 3, 3, 16383, 1'b1,
			tcptmr_pkg::EV_IGNORED, 5, 0));
		plan.push_back(mk(CMD_UNUSED_7,           7, 1, 0, 0,     1'b1,
			tcptmr_pkg::EV_IGNORED, 7, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_ARM_RT, 7, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 7, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_ARM_RT, 7, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_IGNORED, 7, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_ADD,    7, 3, 3, 1,     1'b1,
			tcptmr_pkg::EV_DONE, 7, 3));
		plan.push_back(mk(tcptmr_pkg::CMD_ADD,    7, 0, 0, 16383, 1'b1,
			tcptmr_pkg::EV_DONE, 7, 0));
		// zero countdown, ages through the wrap
		plan.push_back(mk(tcptmr_pkg::CMD_ADD,    0, 0, 2, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_ADD,    0, 1, 1, 2,     1'b1,
			tcptmr_pkg::EV_DONE, 0, 1));
		plan.push_back(mk(tcptmr_pkg::CMD_ARM_TW, 0, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_ARM_RT, 0, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_TICK,   0, 0, 0, 0,     1'b0,
			tcptmr_pkg::EV_DONE, 0, 0));
		// overwrite of a filled slot
		plan.push_back(mk(tcptmr_pkg::CMD_ADD,    7, 3, 1, 2,     1'b1,
			tcptmr_pkg::EV_DONE, 7, 3));
		plan.push_back(mk(tcptmr_pkg::CMD_ARM_TW, 0, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_TICK,   0, 0, 0, 0,     1'b0,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_TICK,   0, 0, 0, 0,     1'b0,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_REMOVE, 7, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 7, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_DIS_RT, 0, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_ADD,    2, 2, 2, 1,     1'b1,
			tcptmr_pkg::EV_DONE, 2, 2));
		plan.push_back(mk(tcptmr_pkg::CMD_ARM_RT, 2, 0, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 2, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_TICK,   0, 0, 0, 0,     1'b0,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_TICK,   0, 0, 0, 0,     1'b0,
			tcptmr_pkg::EV_DONE, 0, 0));
		plan.push_back(mk(tcptmr_pkg::CMD_REMOVE, 2, 2, 0, 0,     1'b1,
			tcptmr_pkg::EV_DONE, 2, 2));

		foreach (plan[i])
			send_item(plan[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				drain_events();
				case (ph)
					1: begin
						new_tw = 16'd1;
						new_rt = 12'd1;
					end
					2: begin
						new_tw = 16'hFFFF;
						new_rt = 12'hFFF;
					end
					3: begin
						new_tw = 16'($urandom_range(2, 40));
						new_rt = 12'($urandom_range(1, 6));
					end
					default: begin
						new_tw = 16'd3;
						new_rt = 12'd2;
					end
				endcase
				reg_write(ADDR_TIMEWAIT, {16'd0, new_tw});
				reg_write(ADDR_RETRANS, {20'd0, new_rt});
				reg_read_check(ADDR_TIMEWAIT, {16'd0, new_tw});
				reg_read_check(ADDR_RETRANS, {20'd0, new_rt});
			end
			// one phase runs back to back with no gaps
			idle_pct = (ph == 1) ? 0 : 35;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == ITEMS_PER_PHASE / 2)
					drain_events();
				row      = '0;
				row.item = random_command();
				send_item(row);
			end
		end

		drain_events();
		repeat (TICK_CYCLES + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
